@@ sv/mlp_forward_tanh_defines.svh @@
// Assertion macros shared by the network inference block.
`ifndef MLP_FORWARD_TANH_DEFINES_SVH
`define MLP_FORWARD_TANH_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MFT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define MFT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/mft_pkg.sv @@
// Shared types, codes and the tanh table for the network inference block.
`timescale 1ns / 1ps

package mft_pkg;

	localparam int MFT_MAX_LAYERS      = 4;
	localparam int MFT_MAX_LAYER_WIDTH = 16;
	localparam int MFT_WEIGHT_DEPTH    = 1024;

	localparam logic [1:0] REQ_WEIGHT = 2'd0;
	localparam logic [1:0] REQ_NEURON = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;

	localparam logic [2:0] CFG_LAYER_COUNT = 3'd0;
	localparam logic [2:0] CFG_SIZE_ZERO   = 3'd1;
	localparam logic [2:0] CFG_SIZE_ONE    = 3'd2;
	localparam logic [2:0] CFG_SIZE_TWO    = 3'd3;
	localparam logic [2:0] CFG_SIZE_THREE  = 3'd4;

	localparam logic [2:0]  LAYER_COUNT_RESET = 3'd2;
	localparam logic [4:0]  LAYER_SIZE_RESET  = 5'd1;
	localparam logic [12:0] TANH_SAT_MAG      = 13'd4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ACT1,
		ST_ACT2,
		ST_WR,
		ST_OUT_RD,
		ST_OUT_LD
	} mft_state_t;

	typedef struct packed {
		logic run_start;
		logic mac_issue;
		logic row_done;
		logic out_rd;
		logic out_load;
		logic out_next;
	} mft_cmd_t;

	typedef struct packed {
		logic busy;
		logic k_last;
		logic j_last;
		logic l_last;
		logic jo_last;
		logic out_free;
	} mft_status_t;

	// Magnitude of tanh at quarter steps, in Q1.12.
	function automatic logic [12:0] tanh_tab(input logic [4:0] idx);
		logic [12:0] v;
		case (idx)
			5'd0:    v = 13'd0;
			5'd1:    v = 13'd1003;
			5'd2:    v = 13'd1893;
			5'd3:    v = 13'd2602;
			5'd4:    v = 13'd3119;
			5'd5:    v = 13'd3475;
			5'd6:    v = 13'd3707;
			5'd7:    v = 13'd3856;
			5'd8:    v = 13'd3949;
			5'd9:    v = 13'd4006;
			5'd10:   v = 13'd4041;
			5'd11:   v = 13'd4062;
			5'd12:   v = 13'd4076;
			5'd13:   v = 13'd4084;
			5'd14:   v = 13'd4089;
			5'd15:   v = 13'd4091;
			5'd16:   v = 13'd4093;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/mft_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mft_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/mft_ctrl.sv @@
// Sequencing state machine for writes, layer evaluation and result delivery.
`timescale 1ns / 1ps

module mft_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_acc,
	input  logic [1:0]           req_type,
	input  mft_pkg::mft_status_t status,
	output mft_pkg::mft_cmd_t    cmd,
	output logic                 in_stall
);

	mft_pkg::mft_state_t state_q;
	mft_pkg::mft_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != mft_pkg::ST_IDLE);
		case (state_q)
			mft_pkg::ST_IDLE: begin
				if (in_acc && (req_type == mft_pkg::REQ_RUN)) begin
					cmd.run_start = 1'b1;
					state_d       = mft_pkg::ST_MAC;
				end
			end
			mft_pkg::ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (status.k_last) begin
					state_d = mft_pkg::ST_DRAIN;
				end
			end
			mft_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_d = mft_pkg::ST_ACT1;
				end
			end
			mft_pkg::ST_ACT1: begin
				state_d = mft_pkg::ST_ACT2;
			end
			mft_pkg::ST_ACT2: begin
				state_d = mft_pkg::ST_WR;
			end
			mft_pkg::ST_WR: begin
				cmd.row_done = 1'b1;
				if (status.j_last && status.l_last) begin
					state_d = mft_pkg::ST_OUT_RD;
				end else begin
					state_d = mft_pkg::ST_MAC;
				end
			end
			mft_pkg::ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = mft_pkg::ST_OUT_LD;
			end
			mft_pkg::ST_OUT_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.jo_last) begin
						state_d = mft_pkg::ST_IDLE;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = mft_pkg::ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = mft_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/mft_datapath.sv @@
// Stores, counters, multiply-accumulate pipe, tanh stages and output register.
`timescale 1ns / 1ps

module mft_datapath #(
	parameter int MAX_LAYERS      = mft_pkg::MFT_MAX_LAYERS,
	parameter int MAX_LAYER_WIDTH = mft_pkg::MFT_MAX_LAYER_WIDTH,
	parameter int WEIGHT_DEPTH    = mft_pkg::MFT_WEIGHT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mft_pkg::mft_cmd_t    cmd,
	output mft_pkg::mft_status_t status,
	input  logic                 in_acc,
	input  logic [1:0]           req_type,
	input  logic [9:0]           slot_index,
	input  logic signed [15:0]   data_value,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [4:0]           cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [3:0]           out_index,
	output logic signed [13:0]   out_value,
	output logic                 last
);

	localparam int IDX_W   = (MAX_LAYER_WIDTH > 1) ? $clog2(MAX_LAYER_WIDTH) : 1;
	localparam int SIZE_W  = $clog2(MAX_LAYER_WIDTH + 1);
	localparam int LAY_W   = $clog2(MAX_LAYERS);
	localparam int NDEPTH  = MAX_LAYERS * MAX_LAYER_WIDTH;
	localparam int NADDR_W = $clog2(NDEPTH);
	localparam int WADDR_W = $clog2(WEIGHT_DEPTH);

	// Size of a layer after clamping to the supported range.
	function automatic logic [SIZE_W-1:0] eff_size(
		input logic [7:0] idx,
		input logic [4:0] s0,
		input logic [4:0] s1,
		input logic [4:0] s2,
		input logic [4:0] s3
	);
		logic [7:0] s;
		case (idx)
			8'd0:    s = 8'(s0);
			8'd1:    s = 8'(s1);
			8'd2:    s = 8'(s2);
			8'd3:    s = 8'(s3);
			default: s = 8'd1;
		endcase
		if (s == 8'd0) begin
			s = 8'd1;
		end
		if (s > 8'(MAX_LAYER_WIDTH)) begin
			s = 8'(MAX_LAYER_WIDTH);
		end
		return SIZE_W'(s);
	endfunction

	logic [2:0] layer_count_q;
	logic [4:0] lsize0_q;
	logic [4:0] lsize1_q;
	logic [4:0] lsize2_q;
	logic [4:0] lsize3_q;

	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   j_q;
	logic [LAY_W-1:0]   l_q;
	logic [WADDR_W-1:0] widx_q;

	logic               rd_v_s1;
	logic               prod_v_s2;
	logic signed [31:0] prod_s2;
	logic signed [31:0] acc_q;
	logic signed [32:0] acc_sum;
	logic signed [31:0] acc_next;

	logic [7:0]        eff_layers;
	logic [SIZE_W-1:0] prev_size;
	logic [SIZE_W-1:0] next_size;
	logic              k_last;
	logic              j_last;
	logic              jo_last;

	logic [NADDR_W-1:0] nbase;
	logic [NADDR_W-1:0] nbase_next;

	logic               w_we;
	logic               n_we;
	logic               in_neuron_wr;
	logic [NADDR_W-1:0] n_waddr;
	logic [15:0]        n_wdata;
	logic [NADDR_W-1:0] n_raddr;
	logic               n_re;
	logic signed [15:0] w_rd;
	logic signed [15:0] n_rd;

	logic signed [19:0] tn_x;
	logic [19:0]        tn_abs;
	logic [3:0]         tn_idx;
	logic [12:0]        tn_t0;
	logic [12:0]        tn_t1;
	logic               tn_neg_s1;
	logic               tn_sat_s1;
	logic [12:0]        tn_t0_s1;
	logic [10:0]        tn_d_s1;
	logic [9:0]         tn_frac_s1;
	logic [20:0]        tn_pf;
	logic [12:0]        tn_mag;
	logic signed [13:0] tn_val;
	logic signed [13:0] act_s2;

	logic               out_valid_q;
	logic [3:0]         out_index_q;
	logic signed [13:0] out_value_q;
	logic               last_q;
	logic               out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= mft_pkg::LAYER_COUNT_RESET;
			lsize0_q      <= mft_pkg::LAYER_SIZE_RESET;
			lsize1_q      <= mft_pkg::LAYER_SIZE_RESET;
			lsize2_q      <= mft_pkg::LAYER_SIZE_RESET;
			lsize3_q      <= mft_pkg::LAYER_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mft_pkg::CFG_LAYER_COUNT: layer_count_q <= cfg_data[2:0];
				mft_pkg::CFG_SIZE_ZERO:   lsize0_q      <= cfg_data;
				mft_pkg::CFG_SIZE_ONE:    lsize1_q      <= cfg_data;
				mft_pkg::CFG_SIZE_TWO:    lsize2_q      <= cfg_data;
				mft_pkg::CFG_SIZE_THREE:  lsize3_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_layers = 8'(layer_count_q);
		if (eff_layers < 8'd2) begin
			eff_layers = 8'd2;
		end
		if (eff_layers > 8'(MAX_LAYERS)) begin
			eff_layers = 8'(MAX_LAYERS);
		end
	end

	assign prev_size = eff_size(8'(l_q), lsize0_q, lsize1_q, lsize2_q, lsize3_q);
	assign next_size = eff_size(8'(l_q) + 8'd1, lsize0_q, lsize1_q, lsize2_q, lsize3_q);
	assign k_last    = ((SIZE_W'(k_q) + SIZE_W'(1)) == prev_size);
	assign j_last    = ((SIZE_W'(j_q) + SIZE_W'(1)) == next_size);
	assign jo_last   = ((SIZE_W'(j_q) + SIZE_W'(1)) == prev_size);

	assign nbase      = NADDR_W'(l_q) * NADDR_W'(MAX_LAYER_WIDTH);
	assign nbase_next = nbase + NADDR_W'(MAX_LAYER_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			j_q    <= '0;
			l_q    <= '0;
			widx_q <= '0;
		end else begin
			if (cmd.run_start) begin
				k_q    <= '0;
				j_q    <= '0;
				l_q    <= '0;
				widx_q <= '0;
			end
			if (cmd.mac_issue) begin
				k_q <= k_last ? '0 : k_q + IDX_W'(1);
				if (widx_q == WADDR_W'(WEIGHT_DEPTH - 1)) begin
					widx_q <= '0;
				end else begin
					widx_q <= widx_q + WADDR_W'(1);
				end
			end
			if (cmd.row_done) begin
				if (j_last) begin
					j_q <= '0;
					l_q <= l_q + LAY_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (cmd.out_next) begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	assign w_we         = in_acc && (req_type == mft_pkg::REQ_WEIGHT)
		&& (17'(slot_index) < 17'(WEIGHT_DEPTH));
	assign in_neuron_wr = in_acc && (req_type == mft_pkg::REQ_NEURON)
		&& (slot_index < 10'(MAX_LAYER_WIDTH));
	assign n_we         = in_neuron_wr || cmd.row_done;
	assign n_waddr      = cmd.row_done ? (nbase_next + NADDR_W'(j_q)) : NADDR_W'(slot_index);
	assign n_wdata      = cmd.row_done ? {{2{act_s2[13]}}, act_s2} : data_value;
	assign n_re         = cmd.mac_issue || cmd.out_rd;
	assign n_raddr      = nbase + (cmd.out_rd ? NADDR_W'(j_q) : NADDR_W'(k_q));

	mft_ram #(
		.WIDTH (16),
		.DEPTH (WEIGHT_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (WADDR_W'(slot_index)),
		.wdata (data_value),
		.re    (cmd.mac_issue),
		.raddr (widx_q),
		.rdata (w_rd)
	);

	mft_ram #(
		.WIDTH (16),
		.DEPTH (NDEPTH)
	) u_neuron_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= cmd.mac_issue;
			prod_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_rd * n_rd;
	end

	assign acc_sum = {acc_q[31], acc_q} + {prod_s2[31], prod_s2};

	always_comb begin
		if (acc_sum[32] != acc_sum[31]) begin
			acc_next = acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			acc_next = acc_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_start || cmd.row_done) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_next;
		end
	end

	// Floor division by 4096 is the arithmetic shift; the table works on |x|.
	assign tn_x   = acc_q[31:12];
	assign tn_abs = tn_x[19] ? 20'(-tn_x) : 20'(tn_x);
	assign tn_idx = tn_abs[13:10];
	assign tn_t0  = mft_pkg::tanh_tab({1'b0, tn_idx});
	assign tn_t1  = mft_pkg::tanh_tab({1'b0, tn_idx} + 5'd1);

	always_ff @(posedge clk) begin
		tn_neg_s1  <= tn_x[19];
		tn_sat_s1  <= |tn_abs[19:14];
		tn_t0_s1   <= tn_t0;
		tn_d_s1    <= 11'(tn_t1 - tn_t0);
		tn_frac_s1 <= tn_abs[9:0];
	end

	assign tn_pf  = 21'(tn_d_s1) * 21'(tn_frac_s1);
	assign tn_mag = tn_sat_s1 ? mft_pkg::TANH_SAT_MAG : (tn_t0_s1 + 13'(tn_pf[20:10]));
	assign tn_val = tn_neg_s1 ? -$signed({1'b0, tn_mag}) : $signed({1'b0, tn_mag});

	always_ff @(posedge clk) begin
		act_s2 <= tn_val;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_index_q <= 4'(j_q);
			out_value_q <= n_rd[13:0];
			last_q      <= jo_last;
		end
	end

	always_comb begin
		status          = '0;
		status.busy     = rd_v_s1 || prod_v_s2;
		status.k_last   = k_last;
		status.j_last   = j_last;
		status.l_last   = ((8'(l_q) + 8'd2) == eff_layers);
		status.jo_last  = jo_last;
		status.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

@@ sv/mlp_forward_tanh.sv @@
// Top level of the fully connected tanh network inference block.
// Weight and neuron writes are accepted back to back while the block is idle.
// A run computes each neuron of every computed layer with one weight read per cycle
// through the single weight memory port, then pipeline drain, two tanh stages and write-back.
// Results then leave one at a time as the output register frees; input stalls until the last one is registered.
// Reset clears control and sets layer count 2 and all layer sizes 1; the stores are not cleared.
`timescale 1ns / 1ps
`include "mlp_forward_tanh_defines.svh"

module mlp_forward_tanh #(
	parameter int MAX_LAYERS      = mft_pkg::MFT_MAX_LAYERS,
	parameter int MAX_LAYER_WIDTH = mft_pkg::MFT_MAX_LAYER_WIDTH,
	parameter int WEIGHT_DEPTH    = mft_pkg::MFT_WEIGHT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [9:0]         slot_index,
	input  logic signed [15:0] data_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         out_index,
	output logic signed [13:0] out_value,
	output logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	mft_pkg::mft_cmd_t    cmd;
	mft_pkg::mft_status_t status;
	logic                 in_acc;

	assign in_acc = in_valid && !in_stall;

	mft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	mft_datapath #(
		.MAX_LAYERS      (MAX_LAYERS),
		.MAX_LAYER_WIDTH (MAX_LAYER_WIDTH),
		.WEIGHT_DEPTH    (WEIGHT_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_acc     (in_acc),
		.req_type   (req_type),
		.slot_index (slot_index),
		.data_value (data_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_index  (out_index),
		.out_value  (out_value),
		.last       (last)
	);

	`MFT_ASSERT_IMPLY(a_row_write_drained, cmd.row_done, !status.busy, "neuron written with MAC pipe busy")
	`MFT_ASSERT_IMPLY(a_load_into_free_slot, cmd.out_load, (!out_valid || !out_stall), "result overwritten")
	`MFT_ASSERT_ALWAYS(a_single_command, ($onehot0({cmd.run_start, cmd.mac_issue, cmd.row_done, cmd.out_rd, cmd.out_load})), "conflicting commands")

endmodule
